// File: sv/deq_pkg.sv
`default_nettype none
package deq_pkg;

    localparam int DEFAULT_CAPACITY = 32;
    localparam int DATA_W           = 32;
    localparam int CMD_W            = 3;
    localparam int STATUS_W         = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SHOW       = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start;    // input word taken this cycle
        logic advance;  // show word taken, fetch the next one
    } t_dp_ctrl;

    // datapath to controller
    typedef struct packed {
        logic known;    // incoming command produces a result
        logic last;     // word on the output is the final one of its command
    } t_dp_stat;

endpackage
`default_nettype wire

// File: sv/deq_ram.sv
`default_nettype none
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: sv/deq_ctrl.sv
`default_nettype none
module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  wire logic     i_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_ctrl      o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && i_stat.known) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_ready && i_stat.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready        = 1'b0;
        o_valid        = 1'b0;
        o_ctrl.start   = 1'b0;
        o_ctrl.advance = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_ctrl.start = i_valid;
            end
            S_RESP: begin
                o_valid        = 1'b1;
                o_ctrl.advance = i_ready && !i_stat.last;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: sv/deq_dp.sv
`default_nettype none
module deq_dp
    import deq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [DATA_W-1:0]   i_value,
    input  wire t_dp_ctrl            i_ctrl,
    output t_dp_stat                 o_stat,
    output logic      [DATA_W-1:0]   o_data,
    output logic      [STATUS_W-1:0] o_status
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] CAP_S   = SUM_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAPACITY);
    localparam logic [PTR_W-1:0] TOP_PTR = PTR_W'(CAPACITY - 1);

    // sum is below twice the capacity, so one subtract folds it back
    function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] d;
        d = (s >= CAP_S) ? s - CAP_S : s;
        return d[PTR_W-1:0];
    endfunction

    logic [PTR_W-1:0] r_front;
    logic [PTR_W-1:0] n_front;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] n_idx;
    t_status          r_status;
    t_status          n_status;
    logic             r_last;
    logic             n_last;
    logic             r_use_rd;
    logic             n_use_rd;

    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic              re;
    logic [PTR_W-1:0]  raddr;
    logic [DATA_W-1:0] rdata;
    logic              full;
    logic              empty;
    t_cmd              cmd;

    assign full  = (r_count == CAP_C);
    assign empty = (r_count == '0);
    assign cmd   = t_cmd'(i_command);

    always_comb begin
        o_stat.last = r_last;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_POP_FRONT, CMD_POP_BACK, CMD_SHOW:
                o_stat.known = 1'b1;
            default:
                o_stat.known = 1'b0;
        endcase
    end

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_idx    = r_idx;
        n_status = r_status;
        n_last   = r_last;
        n_use_rd = r_use_rd;
        we       = 1'b0;
        waddr    = r_front;
        re       = 1'b0;
        raddr    = r_front;
        if (i_ctrl.start) begin
            n_status = ST_OK;
            n_last   = 1'b1;
            n_use_rd = 1'b0;
            case (cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        we      = 1'b1;
                        n_count = r_count + CNT_W'(1);
                        if (cmd == CMD_PUSH_FRONT) begin
                            n_front = (r_front == '0) ? TOP_PTR : r_front - PTR_W'(1);
                            waddr   = n_front;
                        end else begin
                            waddr = wrap(SUM_W'(r_front) + SUM_W'(r_count));
                        end
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        re       = 1'b1;
                        n_use_rd = 1'b1;
                        n_count  = r_count - CNT_W'(1);
                        if (cmd == CMD_POP_FRONT) begin
                            raddr   = r_front;
                            n_front = wrap(SUM_W'(r_front) + SUM_W'(1));
                        end else begin
                            raddr = wrap(SUM_W'(r_front) + SUM_W'(r_count) - SUM_W'(1));
                        end
                    end
                end
                CMD_SHOW: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        re       = 1'b1;
                        n_use_rd = 1'b1;
                        raddr    = r_front;
                        n_idx    = CNT_W'(1);
                        n_last   = (r_count == CNT_W'(1));
                    end
                end
                default: begin
                    n_use_rd = 1'b0;
                end
            endcase
        end else if (i_ctrl.advance) begin
            // fetch the next word of a show
            re     = 1'b1;
            raddr  = wrap(SUM_W'(r_front) + SUM_W'(r_idx));
            n_idx  = r_idx + CNT_W'(1);
            n_last = (n_idx == r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_status <= n_status;
        r_last   <= n_last;
        r_use_rd <= n_use_rd;
    end

    deq_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(i_value),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_data   = r_use_rd ? rdata : '0;
    assign o_status = r_status;

endmodule
`default_nettype wire

// File: sv/double_ended_queue.sv
// Response: the first result word appears in the cycle after the command word is taken.
// Flow: one command in flight; a push or pop returns one word, a show of n entries
// returns n words, one per cycle while i_ready is high, from the single RAM read port.
// Reset: synchronous active-low; clears the front pointer and the fill count, the
// RAM contents are left as they are.
`default_nettype none
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [DATA_W-1:0]   i_value,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic      [DATA_W-1:0]   o_data,
    output logic      [STATUS_W-1:0] o_status,
    output logic                     o_last
);

    t_dp_ctrl dp_ctrl;
    t_dp_stat dp_stat;

    deq_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .i_stat (dp_stat),
        .o_ctrl (dp_ctrl)
    );

    deq_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_command(i_command),
        .i_value  (i_value),
        .i_ctrl   (dp_ctrl),
        .o_stat   (dp_stat),
        .o_data   (o_data),
        .o_status (o_status)
    );

    assign o_last = dp_stat.last;

endmodule
`default_nettype wire
